@@ rtl/core/rbst_pkg.sv @@
// Shared types and widths for the ray versus box slab test.
// No dependencies; imported by every module of the block.
`default_nettype none

package rbst_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = CoordW + 1;
  localparam int OpW    = CoordW + 2;
  localparam int ProdW  = 2 * CoordW + 2;
  localparam int TolW   = 16;
  localparam int AxisN  = 3;
  localparam int MaskW  = 3;

  localparam logic [0:0] ReqLoad = 1'b0;
  localparam logic [0:0] ReqTest = 1'b1;

  localparam logic [ProdW-1:0] ProdMin = {1'b1, {(ProdW-1){1'b0}}};
  localparam logic [ProdW-1:0] ProdMax = {1'b0, {(ProdW-1){1'b1}}};

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

  typedef struct packed {
    logic             fail;
    logic [ProdW-1:0] lo;
    logic [ProdW-1:0] hi;
  } lane_res_t;

endpackage

`default_nettype wire

@@ rtl/core/ray_box_slab_test_top.sv @@
// Top level of the ray versus box slab test: ray and tolerance registers,
// valid chain, three rbst_axis lanes and rbst_merge. Depends on rbst_pkg.
//
//   channel  signals                                  direction
//   in       in_valid_i/in_ready_o, req_type_i,       sink
//            first_*_i, second_*_i, parallel_mask_i
//   out      out_valid_o/out_ready_i, hit_o           source
//   cfg      cfg_valid_i/cfg_ready_o, cfg_tolerance_i sink
//
// One word per cycle; a box test gives its hit through six register stages
// (difference, multiply, min/max, two reduction stages, gap compare). A ray
// load updates the ray registers at acceptance and gives no word.
// Each stage holds while the next is full and stalled; bubbles collapse.
// Reset clears valids, the ray and the parallel mask, and sets tolerance to 1.
`default_nettype none

module ray_box_slab_test_top
  import rbst_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     req_type_i,
  input  logic signed [CoordW-1:0] first_x_i,
  input  logic signed [CoordW-1:0] first_y_i,
  input  logic signed [CoordW-1:0] first_z_i,
  input  logic signed [CoordW-1:0] second_x_i,
  input  logic signed [CoordW-1:0] second_y_i,
  input  logic signed [CoordW-1:0] second_z_i,
  input  logic [MaskW-1:0]         parallel_mask_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     hit_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [TolW-1:0]          cfg_tolerance_i
);

  logic [TolW-1:0]          tol_q;
  logic signed [CoordW-1:0] origin_q  [AxisN];
  logic signed [CoordW-1:0] inverse_q [AxisN];
  logic [MaskW-1:0]         par_q;
  logic [ProdW-1:0]         tolp;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic in_fire, load_fire;
  stage_en_t en;

  logic signed [CoordW-1:0] lo_corner [AxisN];
  logic signed [CoordW-1:0] hi_corner [AxisN];
  lane_res_t                lane_res  [AxisN];

  assign rdy6 = !v6_q || out_ready_i;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign en = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5, s6: rdy6};

  assign in_ready_o  = rdy1;
  assign out_valid_o = v6_q;
  assign cfg_ready_o = 1'b1;

  assign in_fire   = in_valid_i && in_ready_o;
  assign load_fire = in_fire && (req_type_i == ReqLoad);

  assign tolp = ProdW'(tol_q) << FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_fire && (req_type_i == ReqTest);
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_tolerance_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AxisN; a++) begin
        origin_q[a]  <= '0;
        inverse_q[a] <= '0;
      end
      par_q <= '0;
    end else if (load_fire) begin
      origin_q[0]  <= first_x_i;
      origin_q[1]  <= first_y_i;
      origin_q[2]  <= first_z_i;
      inverse_q[0] <= second_x_i;
      inverse_q[1] <= second_y_i;
      inverse_q[2] <= second_z_i;
      par_q        <= parallel_mask_i;
    end
  end

  assign lo_corner[0] = first_x_i;
  assign lo_corner[1] = first_y_i;
  assign lo_corner[2] = first_z_i;
  assign hi_corner[0] = second_x_i;
  assign hi_corner[1] = second_y_i;
  assign hi_corner[2] = second_z_i;

  for (genvar a = 0; a < AxisN; a++) begin : g_lane
    rbst_axis u_axis (
      .clk_i      (clk_i),
      .en_i       (en),
      .lo_corner_i(lo_corner[a]),
      .hi_corner_i(hi_corner[a]),
      .origin_i   (origin_q[a]),
      .inverse_i  (inverse_q[a]),
      .par_i      (par_q[a]),
      .tolp_i     (tolp),
      .res_o      (lane_res[a])
    );
  end

  rbst_merge u_merge (
    .clk_i (clk_i),
    .en_i  (en),
    .lane_i(lane_res),
    .tolp_i(tolp),
    .hit_o (hit_o)
  );

`ifndef SYNTHESIS
  a_load_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |=> !v1_q)
    else $error("ray load entered the pipeline");

  a_test_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (req_type_i == ReqTest)) |=> v1_q)
    else $error("accepted box test lost at entry");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !rdy4) |=> v4_q)
    else $error("stalled stage dropped its word");
`endif

endmodule

`default_nettype wire

@@ rtl/core/rbst_axis.sv @@
// One axis lane: corner minus origin, slab products, min/max or parallel check.
// Depends on rbst_pkg; three register stages driven by the top level enables.
`default_nettype none

module rbst_axis
  import rbst_pkg::*;
(
  input  logic                     clk_i,
  input  stage_en_t                en_i,
  input  logic signed [CoordW-1:0] lo_corner_i,
  input  logic signed [CoordW-1:0] hi_corner_i,
  input  logic signed [CoordW-1:0] origin_i,
  input  logic signed [CoordW-1:0] inverse_i,
  input  logic                     par_i,
  input  logic [ProdW-1:0]         tolp_i,
  output lane_res_t                res_o
);

  logic signed [DiffW-1:0]  da_d, db_d, da_q, db_q;
  logic signed [CoordW-1:0] inv_q;
  logic                     par1_q;

  logic signed [OpW-1:0]    da_x, db_x, inv_x, ma, mb, op_a, op_b;
  logic signed [2*OpW-1:0]  mul_a, mul_b;
  logic                     opp_d;
  logic signed [ProdW-1:0]  pa_q, pb_q;
  logic                     par2_q, opp2_q;

  logic [ProdW-1:0]         lo_d, hi_d, lo_q, hi_q;
  logic                     fail_d, fail3_q;

  assign da_d = DiffW'(lo_corner_i) - DiffW'(origin_i);
  assign db_d = DiffW'(hi_corner_i) - DiffW'(origin_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      da_q   <= da_d;
      db_q   <= db_d;
      inv_q  <= inverse_i;
      par1_q <= par_i;
    end
  end

  assign da_x  = OpW'(da_q);
  assign db_x  = OpW'(db_q);
  assign inv_x = OpW'(inv_q);
  assign ma    = da_q[DiffW-1] ? -da_x : da_x;
  assign mb    = db_q[DiffW-1] ? -db_x : db_x;
  assign op_a  = par1_q ? ma : da_x;
  assign op_b  = par1_q ? mb : inv_x;
  assign mul_a = op_a * op_b;
  assign mul_b = db_x * inv_x;
  assign opp_d = (da_q[DiffW-1] && !db_q[DiffW-1] && (|db_q)) ||
                 (db_q[DiffW-1] && !da_q[DiffW-1] && (|da_q));

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      pa_q   <= mul_a[ProdW-1:0];
      pb_q   <= mul_b[ProdW-1:0];
      par2_q <= par1_q;
      opp2_q <= opp_d;
    end
  end

  assign lo_d   = (pa_q < pb_q) ? pa_q : pb_q;
  assign hi_d   = (pa_q < pb_q) ? pb_q : pa_q;
  assign fail_d = !opp2_q || ($unsigned(pa_q) < tolp_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      lo_q    <= par2_q ? ProdMin : lo_d;
      hi_q    <= par2_q ? ProdMax : hi_d;
      fail3_q <= par2_q && fail_d;
    end
  end

  assign res_o.fail = fail3_q;
  assign res_o.lo   = lo_q;
  assign res_o.hi   = hi_q;

endmodule

`default_nettype wire

@@ rtl/core/rbst_merge.sv @@
// Entry/exit reduction over the three lanes and the final gap compare.
// Depends on rbst_pkg; stages four to six driven by the top level enables.
`default_nettype none

module rbst_merge
  import rbst_pkg::*;
(
  input  logic             clk_i,
  input  stage_en_t        en_i,
  input  lane_res_t        lane_i [AxisN],
  input  logic [ProdW-1:0] tolp_i,
  output logic             hit_o
);

  logic [ProdW-1:0]        e01_q, l01_q, lo2_q, hi2_q;
  logic                    fail4_q;
  logic [ProdW-1:0]        enter_d, leave_d, enter_q, leave_q;
  logic                    fail5_q;
  logic signed [ProdW:0]   gap;
  logic                    hit_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      e01_q   <= ($signed(lane_i[0].lo) > $signed(lane_i[1].lo)) ? lane_i[0].lo : lane_i[1].lo;
      l01_q   <= ($signed(lane_i[0].hi) < $signed(lane_i[1].hi)) ? lane_i[0].hi : lane_i[1].hi;
      lo2_q   <= lane_i[2].lo;
      hi2_q   <= lane_i[2].hi;
      fail4_q <= lane_i[0].fail || lane_i[1].fail || lane_i[2].fail;
    end
  end

  assign enter_d = ($signed(e01_q) > $signed(lo2_q)) ? e01_q : lo2_q;
  assign leave_d = ($signed(l01_q) < $signed(hi2_q)) ? l01_q : hi2_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      enter_q <= enter_d;
      leave_q <= leave_d;
      fail5_q <= fail4_q;
    end
  end

  assign gap = $signed({leave_q[ProdW-1], leave_q}) - $signed({enter_q[ProdW-1], enter_q});

  always_ff @(posedge clk_i) begin
    if (en_i.s6) begin
      hit_q <= !fail5_q && (gap > $signed({1'b0, tolp_i}));
    end
  end

  assign hit_o = hit_q;

endmodule

`default_nettype wire

@@ bench/ray_box_slab_test_top_tb.sv @@
// Self-checking bench for ray_box_slab_test_top: ray loads and box tests over handshaked
// channels with random idling, checked against an in-bench slab-test predictor.
// Depends on rbst_pkg and the ray_box_slab_test_top RTL.
`timescale 1ns / 1ps

module ray_box_slab_test_top_tb;
  import rbst_pkg::*;

  localparam int FracBits    = 16;
  localparam int PhaseWords  = 160;
  localparam int SettleCycles = 12;
  localparam int LongHold    = 400;
  localparam int CoordLo     = 32'h8000_0000;
  localparam int CoordHi     = 32'h7fff_ffff;
  localparam int One         = 32'h0001_0000;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [0:0]                   req;
    logic [AxisN-1:0][CoordW-1:0] first;
    logic [AxisN-1:0][CoordW-1:0] second;
    logic [MaskW-1:0]             mask;
  } ray_box_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  ray_box_word_t       tx_word = '0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [TolW-1:0]     cfg_tolerance = '0;
  logic                in_ready;
  logic                out_valid;
  logic                hit;
  logic                cfg_ready;

  logic [CoordW-1:0] ray_org [AxisN] = '{default: '0};
  logic [CoordW-1:0] ray_inv [AxisN] = '{default: '0};
  logic [MaskW-1:0]  ray_par = '0;
  logic [TolW-1:0]   tol_reg = 16'd1;

  ray_box_word_t queued_reqs [$];
  logic          expected_hits [$];
  int            gen_org [AxisN] = '{default: 0};

  logic calm = 1'b0;
  logic long_hold_armed = 1'b0;
  logic long_hold_on = 1'b0;
  logic long_hold_done = 1'b0;
  int   tx_gap = 0;
  int   rx_idle = 0;
  logic want_hit;

  int n_loads = 0;
  int n_tests = 0;
  int n_hits = 0;
  int n_misses = 0;
  int n_err = 0;
  int n_settings = 1;

  ray_box_slab_test_top #(
    .FRAC_BITS(FracBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (tx_word.req),
    .first_x_i      (tx_word.first[0]),
    .first_y_i      (tx_word.first[1]),
    .first_z_i      (tx_word.first[2]),
    .second_x_i     (tx_word.second[0]),
    .second_y_i     (tx_word.second[1]),
    .second_z_i     (tx_word.second[2]),
    .parallel_mask_i(tx_word.mask),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .hit_o          (hit),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_tolerance_i(cfg_tolerance)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic slab_hit(ray_box_word_t w);
    longint lo_d, hi_d, t0, t1, enter, leave;
    longint unsigned tol_fx, gap;
    logic bounded;
    bounded = 1'b0;
    enter = 0;
    leave = 0;
    tol_fx = longint'(tol_reg) << FracBits;
    for (int a = 0; a < AxisN; a++) begin
      lo_d = longint'($signed(w.first[a])) - longint'($signed(ray_org[a]));
      hi_d = longint'($signed(w.second[a])) - longint'($signed(ray_org[a]));
      if (ray_par[a]) begin
        if (!((lo_d < 0 && hi_d > 0) || (lo_d > 0 && hi_d < 0))) return 1'b0;
        if (longint'(unsigned'(lo_d < 0 ? -lo_d : lo_d)) == 0) return 1'b0;
        if ((u64_t'(lo_d < 0 ? -lo_d : lo_d)) *
            (u64_t'(hi_d < 0 ? -hi_d : hi_d)) < tol_fx) return 1'b0;
      end else begin
        t0 = lo_d * longint'($signed(ray_inv[a]));
        t1 = hi_d * longint'($signed(ray_inv[a]));
        if (!bounded) begin
          enter = (t0 < t1) ? t0 : t1;
          leave = (t0 < t1) ? t1 : t0;
          bounded = 1'b1;
        end else begin
          if (((t0 < t1) ? t0 : t1) > enter) enter = (t0 < t1) ? t0 : t1;
          if (((t0 < t1) ? t1 : t0) < leave) leave = (t0 < t1) ? t1 : t0;
        end
      end
    end
    if (bounded) begin
      if (leave < enter) return 1'b0;
      gap = u64_t'(leave) - u64_t'(enter);
      if (gap <= tol_fx) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic ray_box_word_t load_word(int ox, int oy, int oz,
                                              int ix, int iy, int iz,
                                              logic [MaskW-1:0] m);
    ray_box_word_t w;
    w.req = ReqLoad;
    w.first = {oz, oy, ox};
    w.second = {iz, iy, ix};
    w.mask = m;
    return w;
  endfunction

  function automatic ray_box_word_t test_word(int lx, int ly, int lz,
                                              int hx, int hy, int hz);
    ray_box_word_t w;
    w.req = ReqTest;
    w.first = {lz, ly, lx};
    w.second = {hz, hy, hx};
    w.mask = MaskW'($urandom_range(0, 7));
    return w;
  endfunction

  // Mostly boxes placed around the last ray loaded, some loads, some raw noise.
  function automatic ray_box_word_t next_random_word();
    ray_box_word_t w;
    int pick, lo, hi, sw;
    w = '0;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      w.req = 1'($urandom_range(0, 1));
      for (int a = 0; a < AxisN; a++) begin
        w.first[a] = $urandom;
        w.second[a] = $urandom;
      end
      w.mask = MaskW'($urandom_range(0, 7));
    end else if (pick < 22) begin
      w.req = ReqLoad;
      for (int a = 0; a < AxisN; a++) begin
        w.first[a] = int'($urandom_range(0, 2 << 20)) - (1 << 20);
        w.second[a] = ($urandom_range(0, 7) == 0) ? $urandom
                      : int'($urandom_range(0, 2 << 17)) - (1 << 17);
        w.mask[a] = ($urandom_range(0, 3) == 0);
      end
    end else begin
      w.req = ReqTest;
      w.mask = MaskW'($urandom_range(0, 7));
      for (int a = 0; a < AxisN; a++) begin
        if ($urandom_range(0, 2) == 0) begin
          lo = gen_org[a] - int'($urandom_range(1, 1 << 16));
          hi = gen_org[a] + int'($urandom_range(1, 1 << 16));
        end else begin
          lo = gen_org[a] + int'($urandom_range(0, 2 << 18)) - (1 << 18);
          hi = lo + int'($urandom_range(0, 1 << 19));
        end
        if ($urandom_range(0, 7) == 0) begin
          sw = lo;
          lo = hi;
          hi = sw;
        end
        w.first[a] = lo;
        w.second[a] = hi;
      end
    end
    if (w.req == ReqLoad) begin
      for (int a = 0; a < AxisN; a++) gen_org[a] = w.first[a];
    end
    return w;
  endfunction

  task automatic write_tolerance(input logic [TolW-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_tolerance <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_reg = value;
  endtask

  task automatic drain_and_settle();
    while (queued_reqs.size() != 0 || in_valid || expected_hits.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_word <= '0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (tx_word.req == ReqLoad) begin
          for (int a = 0; a < AxisN; a++) begin
            ray_org[a] = tx_word.first[a];
            ray_inv[a] = tx_word.second[a];
          end
          ray_par = tx_word.mask;
          n_loads++;
        end else begin
          expected_hits.push_back(slab_hit(tx_word));
          n_tests++;
        end
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (queued_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && !long_hold_on && $urandom_range(0, 11) == 0) begin
          tx_gap <= $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else begin
          tx_word <= queued_reqs.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_idle <= 0;
      long_hold_on <= 1'b0;
      long_hold_done <= 1'b0;
    end else if (long_hold_armed && !long_hold_done) begin
      out_ready <= 1'b0;
      rx_idle <= LongHold;
      long_hold_on <= 1'b1;
      long_hold_done <= 1'b1;
    end else if (rx_idle != 0) begin
      out_ready <= 1'b0;
      rx_idle <= rx_idle - 1;
    end else begin
      long_hold_on <= 1'b0;
      if (!calm && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        rx_idle <= $urandom_range(0, 17);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected hit word: got %0b", hit);
      end else begin
        want_hit = expected_hits.pop_front();
        if (hit !== want_hit) begin
          n_err++;
          if (n_err <= 10) begin
            $display("hit mismatch on box test %0d: expected %0b, got %0b",
                     n_hits + n_misses, want_hit, hit);
          end
        end
      end
      if (hit === 1'b1) n_hits++;
      else n_misses++;
    end
  end

  initial begin
    logic [TolW-1:0] tol_plan [6];
    tol_plan[0] = '0;
    tol_plan[1] = '1;
    tol_plan[2] = TolW'($urandom_range(1, 64));
    tol_plan[3] = TolW'($urandom_range(0, 65535));
    tol_plan[4] = 16'd1;
    tol_plan[5] = TolW'($urandom_range(0, 65535));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queued_reqs.push_back(test_word(-One, -One, -One, One, One, One));
    queued_reqs.push_back(test_word(CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi));
    queued_reqs.push_back(load_word(0, 0, 0, One, One, One, 3'b000));
    queued_reqs.push_back(test_word(-One, -One, -One, One, One, One));
    queued_reqs.push_back(test_word(0, 0, 0, 1, 1, 1));
    queued_reqs.push_back(test_word(0, 0, 0, 2, 2, 2));
    queued_reqs.push_back(test_word(10, 30, -5, 20, 40, 50));
    queued_reqs.push_back(test_word(One, One, One, -One, -One, -One));
    queued_reqs.push_back(load_word(0, 0, 0, One, One, One, 3'b010));
    queued_reqs.push_back(test_word(-One, -256, -One, One, 256, One));
    queued_reqs.push_back(test_word(-One, -255, -One, One, 256, One));
    queued_reqs.push_back(test_word(-One, 0, -One, One, One, One));
    queued_reqs.push_back(test_word(-One, 256, -One, One, -256, One));
    queued_reqs.push_back(load_word(0, 0, 0, 0, 0, 0, 3'b111));
    queued_reqs.push_back(test_word(-One, -One, -One, One, One, One));
    queued_reqs.push_back(test_word(-1, -1, -1, 1, 1, 1));
    queued_reqs.push_back(test_word(CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi));
    queued_reqs.push_back(load_word(CoordLo, CoordLo, CoordLo, CoordLo, CoordLo, CoordLo,
                                    3'b000));
    queued_reqs.push_back(test_word(CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi));
    queued_reqs.push_back(load_word(CoordHi, CoordHi, CoordHi, CoordHi, CoordHi, CoordHi,
                                    3'b101));
    queued_reqs.push_back(test_word(CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi));
    queued_reqs.push_back(test_word(CoordHi, CoordLo, CoordHi, CoordLo, CoordHi, CoordLo));
    queued_reqs.push_back(load_word(One, -One, 0, -One, -2 * One, One / 2, 3'b000));
    queued_reqs.push_back(test_word(0, -3 * One, -One, 2 * One, One, One));
    drain_and_settle();

    for (int p = 0; p < 6; p++) begin
      write_tolerance(tol_plan[p]);
      n_settings++;
      @(negedge clk_i);
      calm = (p == 5);
      for (int k = 0; k < PhaseWords; k++) queued_reqs.push_back(next_random_word());
      if (p == 0) long_hold_armed = 1'b1;
      drain_and_settle();
    end

    $display("covered %0d ray loads and %0d box tests under %0d tolerance values",
             n_loads, n_tests, n_settings);
    $display("boxes hit %0d, missed %0d, mismatching words %0d", n_hits, n_misses, n_err);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d hit words outstanding", expected_hits.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
